/* hw/rtl/polyphase_rational_resampler_defines.svh */
// ----------------------------------------------------------------------------
// Polyphase rational resampler assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_RATIONAL_RESAMPLER_DEFINES_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_DEFINES_SVH

`ifndef SYNTH
`define PRR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define PRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRR_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/prr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler package
// Field widths, register indexes, write-data selects and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int CIDX_W     = 8;
    localparam int FACTOR_W   = 5;
    localparam int TAPS_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int FRAC_BITS  = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

    localparam logic [FACTOR_W-1:0] INTERP_RESET = 5'd1;
    localparam logic [FACTOR_W-1:0] DECIM_RESET  = 5'd1;
    localparam logic [TAPS_W-1:0]   TAPS_RESET   = 9'd64;

    localparam logic OP_LOAD_COEFF = 1'b0;
    localparam logic OP_SAMPLE     = 1'b1;

    // delay line write data select
    localparam logic [1:0] DL_WSEL_ZERO   = 2'd0;
    localparam logic [1:0] DL_WSEL_SHIFT  = 2'd1;
    localparam logic [1:0] DL_WSEL_SAMPLE = 2'd2;

    typedef struct packed {
        logic       coeff_we;
        logic       cap_sample;
        logic       dl_we;
        logic [1:0] dl_wsel;
        logic       mac_clear;
        logic       mac_issue;
        logic       out_load;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic mac_idle;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/prr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/prr_ctrl.sv */
`timescale 1ns / 1ps
`include "polyphase_rational_resampler_defines.svh"
// ----------------------------------------------------------------------------
// Polyphase rational resampler controller
// Holds the configuration registers, sequences the delay line clear and
// shift, the polyphase phases, the decimation counter and the MAC passes.
// ----------------------------------------------------------------------------
module prr_ctrl
    import prr_pkg::*;
#(
    parameter int MAX_TAPS   = 256,
    parameter int MAX_FACTOR = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  status_t                     status,
    output cmd_t                        cmd,
    output logic [$clog2(MAX_TAPS)-1:0] dl_raddr,
    output logic [$clog2(MAX_TAPS)-1:0] dl_waddr,
    output logic [$clog2(MAX_TAPS)-1:0] cf_raddr
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int PW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int SW = $clog2(MAX_TAPS + MAX_FACTOR + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SHIFT  = 4'd2;
    localparam logic [3:0] S_SHEND  = 4'd3;
    localparam logic [3:0] S_INSERT = 4'd4;
    localparam logic [3:0] S_PHASE  = 4'd5;
    localparam logic [3:0] S_MAC    = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;
    localparam logic [3:0] S_ADV    = 4'd9;

    logic [FACTOR_W-1:0] interp_reg;
    logic [FACTOR_W-1:0] decim_reg;
    logic [TAPS_W-1:0]   taps_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] sh_reg, sh_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] dphase_reg, dphase_next;
    logic [AW-1:0] j_reg, j_next;
    logic [SW-1:0] base_reg, base_next;

    logic [FW-1:0] l_eff;
    logic [FW-1:0] m_eff;
    logic [TW-1:0] taps_eff;
    logic          issue_ok;
    logic          last_result;
    logic          last_phase;
    logic [SW-1:0] cidx;

    // clamp the factors and the tap count into their working ranges
    always_comb
    begin
        if (interp_reg == '0)
            l_eff = FW'(1);
        else if (32'(interp_reg) > MAX_FACTOR)
            l_eff = FW'(MAX_FACTOR);
        else
            l_eff = FW'(interp_reg);

        if (decim_reg == '0)
            m_eff = FW'(1);
        else if (32'(decim_reg) > MAX_FACTOR)
            m_eff = FW'(MAX_FACTOR);
        else
            m_eff = FW'(decim_reg);

        if (taps_reg == '0)
            taps_eff = TW'(1);
        else if (32'(taps_reg) > MAX_TAPS)
            taps_eff = TW'(MAX_TAPS);
        else
            taps_eff = TW'(taps_reg);
    end

    // tap j is in the sum while (j + 1) * L <= taps
    assign issue_ok    = (base_reg + SW'(l_eff)) <= SW'(taps_eff);
    assign cidx        = base_reg + SW'(p_reg);
    // the next emitting phase of this sample would be p + M
    assign last_result = ((FW + 1)'(p_reg) + (FW + 1)'(m_eff)) >= (FW + 1)'(l_eff);
    assign last_phase  = FW'(p_reg) == (l_eff - FW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= INTERP_RESET;
            decim_reg  <= DECIM_RESET;
            taps_reg   <= TAPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INTERP: interp_reg <= cfg_wdata[FACTOR_W-1:0];
                CFG_DECIM:  decim_reg  <= cfg_wdata[FACTOR_W-1:0];
                CFG_TAPS:   taps_reg   <= cfg_wdata[TAPS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sh_next        = sh_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        p_next         = p_reg;
        dphase_next    = dphase_reg;
        j_next         = j_reg;
        base_next      = base_reg;

        cmd      = '0;
        in_ready = 1'b0;
        dl_raddr = '0;
        dl_waddr = '0;
        cf_raddr = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.dl_we   = 1'b1;
                cmd.dl_wsel = DL_WSEL_ZERO;
                dl_waddr    = clr_reg;
                clr_next    = AW'(clr_reg + 1'b1);
                if (clr_reg == AW'(MAX_TAPS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == OP_LOAD_COEFF)
                    begin
                        cmd.coeff_we = 1'b1;
                    end
                    else
                    begin
                        cmd.cap_sample = 1'b1;
                        pend_next      = 1'b0;
                        sh_next        = AW'(taps_eff - TW'(2));
                        if (taps_eff == TW'(1))
                            state_next = S_INSERT;
                        else
                            state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // read tap k now, write it to k + 1 in the next cycle
                dl_raddr = sh_reg;
                if (pend_reg)
                begin
                    cmd.dl_we   = 1'b1;
                    cmd.dl_wsel = DL_WSEL_SHIFT;
                    dl_waddr    = pend_addr_reg;
                end
                pend_next      = 1'b1;
                pend_addr_next = AW'(sh_reg + 1'b1);
                if (sh_reg == '0)
                    state_next = S_SHEND;
                else
                    sh_next = AW'(sh_reg - 1'b1);
            end

            S_SHEND:
            begin
                cmd.dl_we   = 1'b1;
                cmd.dl_wsel = DL_WSEL_SHIFT;
                dl_waddr    = pend_addr_reg;
                pend_next   = 1'b0;
                state_next  = S_INSERT;
            end

            S_INSERT:
            begin
                cmd.dl_we   = 1'b1;
                cmd.dl_wsel = DL_WSEL_SAMPLE;
                dl_waddr    = '0;
                p_next      = '0;
                state_next  = S_PHASE;
            end

            S_PHASE:
            begin
                if (dphase_reg == '0)
                begin
                    cmd.mac_clear = 1'b1;
                    base_next     = '0;
                    j_next        = '0;
                    state_next    = S_MAC;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end

            S_MAC:
            begin
                if (issue_ok)
                begin
                    cmd.mac_issue = 1'b1;
                    dl_raddr      = j_reg;
                    cf_raddr      = AW'(cidx);
                    j_next        = AW'(j_reg + 1'b1);
                    base_next     = base_reg + SW'(l_eff);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (status.mac_idle)
                    state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_result;
                    state_next   = S_ADV;
                end
            end

            S_ADV:
            begin
                // wrap also covers a phase left stale by a lowered M
                if ((FW'(dphase_reg) + FW'(1)) >= m_eff)
                    dphase_next = '0;
                else
                    dphase_next = PW'(dphase_reg + 1'b1);
                if (last_phase)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = PW'(p_reg + 1'b1);
                    state_next = S_PHASE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sh_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            p_reg         <= '0;
            dphase_reg    <= '0;
            j_reg         <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sh_reg        <= sh_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            p_reg         <= p_next;
            dphase_reg    <= dphase_next;
            j_reg         <= j_next;
            base_reg      <= base_next;
        end
    end

    `PRR_ASSERT_ALWAYS(a_load_when_free, clk, rst_n, !cmd.out_load || status.out_free)
    `PRR_ASSERT_IMPL(a_coeff_in_range, clk, rst_n, cmd.mac_issue, cidx < SW'(taps_eff))
    `PRR_ASSERT_IMPL(a_shift_no_clash, clk, rst_n, state_reg == S_SHIFT && pend_reg, dl_raddr != dl_waddr)
    `PRR_ASSERT_NEXT(a_load_then_adv, clk, rst_n, cmd.out_load, state_reg == S_ADV)

endmodule

/* hw/rtl/prr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler datapath
// Coefficient and delay line memories, the multiply-accumulate pipeline,
// shift with saturation and the output register.
// ----------------------------------------------------------------------------
module prr_dp
    import prr_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  logic [$clog2(MAX_TAPS)-1:0] dl_raddr,
    input  logic [$clog2(MAX_TAPS)-1:0] dl_waddr,
    input  logic [$clog2(MAX_TAPS)-1:0] cf_raddr,
    input  logic [CIDX_W-1:0]           coeff_index,
    input  logic signed [COEFF_W-1:0]   coeff_value,
    input  logic signed [SAMPLE_W-1:0]  sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  out_sample,
    output logic                        last,
    output logic                        saturated
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam int TOP_B = FRAC_BITS + SAMPLE_W - 1;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0]        dl_wdata;
    logic [SAMPLE_W-1:0]        dl_rdata;
    logic [COEFF_W-1:0]         cf_rdata;
    logic                       cf_we;

    logic                       rd_valid_reg;
    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic [ACC_W-1-TOP_B:0]     acc_hi;
    logic                       fits;
    logic signed [SAMPLE_W-1:0] sat_value;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;
    logic                       out_sat_reg;

    // drop writes beyond the store
    assign cf_we = cmd.coeff_we && (32'(coeff_index) < MAX_TAPS);

    always_comb
    begin
        case (cmd.dl_wsel)
            DL_WSEL_ZERO:   dl_wdata = '0;
            DL_WSEL_SHIFT:  dl_wdata = dl_rdata;
            DL_WSEL_SAMPLE: dl_wdata = sample_reg;
            default:        dl_wdata = '0;
        endcase
    end

    prr_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (MAX_TAPS)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (cf_we),
        .waddr (AW'(coeff_index)),
        .wdata (coeff_value),
        .raddr (cf_raddr),
        .rdata (cf_rdata)
    );

    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (cmd.dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_sample)
            sample_reg <= sample;
        prod_reg <= $signed(dl_rdata) * $signed(cf_rdata);
        if (cmd.mac_clear)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.mac_issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // floor shift by 15, then clip when the upper bits are not all sign
    assign acc_hi    = acc_reg[ACC_W-1:TOP_B];
    assign fits      = (&acc_hi) || !(|acc_hi);
    assign sat_value = acc_reg[ACC_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W - 1){1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sample_reg <= fits ? acc_reg[TOP_B:FRAC_BITS] : sat_value;
            out_sat_reg    <= !fits;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign status.mac_idle = !rd_valid_reg && !prod_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign last       = out_last_reg;
    assign saturated  = out_sat_reg;

endmodule

/* hw/rtl/polyphase_rational_resampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler
// Interpolate by L, decimate by M with a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// After reset the block sweeps the delay line to zero, one entry a cycle, and
// accepts no item until the sweep is done; configuration writes are taken at any
// time. A coefficient load is written as it is accepted. A sample first
// shifts the delay line memory (one read and one write port), then walks its
// phases: a phase without a result only advances, and a phase with a result
// runs the single multiply-accumulate unit, which walks the taps one per
// cycle, then waits for it to drain and loads the output register. A finished
// result sits in the output register and the next item is accepted meanwhile; a
// second result waits only while that register is still full.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler
    import prr_pkg::*;
#(
    parameter int MAX_TAPS   = 256,
    parameter int MAX_FACTOR = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic [CIDX_W-1:0]          coeff_index,
    input  logic signed [COEFF_W-1:0]  coeff_value,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic                       last,
    output logic                       saturated
);

    localparam int AW = $clog2(MAX_TAPS);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] dl_raddr;
    logic [AW-1:0] dl_waddr;
    logic [AW-1:0] cf_raddr;

    prr_ctrl #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .status    (status),
        .cmd       (cmd),
        .dl_raddr  (dl_raddr),
        .dl_waddr  (dl_waddr),
        .cf_raddr  (cf_raddr)
    );

    prr_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .dl_raddr    (dl_raddr),
        .dl_waddr    (dl_waddr),
        .cf_raddr    (cf_raddr),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .last        (last),
        .saturated   (saturated)
    );

endmodule

/* dv/prr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler result checker
// Follows register writes and accepted items, computes the expected output
// stream of the resampler and compares every output transfer, field by
// field, with the oldest expected result.
// ----------------------------------------------------------------------------
module prr_checker
    import prr_pkg::*;
#(
    parameter int MAX_TAPS   = 256,
    parameter int MAX_FACTOR = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       op,
    input  logic [CIDX_W-1:0]          coeff_index,
    input  logic signed [COEFF_W-1:0]  coeff_value,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] out_sample,
    input  logic                       last,
    input  logic                       saturated,
    output int                         mismatches,
    output int                         outstanding
);

    localparam logic signed [39:0] OUT_MAX = 40'sd32767;
    localparam logic signed [39:0] OUT_MIN = -40'sd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        logic                       sat;
    } result_t;

    logic [FACTOR_W-1:0]        interp_q;
    logic [FACTOR_W-1:0]        decim_q;
    logic [TAPS_W-1:0]          taps_q;
    logic signed [COEFF_W-1:0]  coeffs [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic [3:0]                 decim_cnt;
    result_t                    expected_q [$];

    function automatic int eff_factor(input logic [FACTOR_W-1:0] f);
        if (f == 0) return 1;
        if (f > MAX_FACTOR) return MAX_FACTOR;
        return int'(f);
    endfunction

    function automatic int eff_taps(input logic [TAPS_W-1:0] t);
        if (t == 0) return 1;
        if (t > MAX_TAPS) return MAX_TAPS;
        return int'(t);
    endfunction

    // Shift one sample in, then walk the phases and queue the results it causes.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        int                n_phase;
        int                n_div;
        int                n_taps;
        int                len;
        int                first;
        logic signed [39:0] acc;
        logic signed [39:0] scaled;
        result_t           r;
        n_phase = eff_factor(interp_q);
        n_div   = eff_factor(decim_q);
        n_taps  = eff_taps(taps_q);
        len     = n_taps / n_phase;
        first   = expected_q.size();
        for (int j = n_taps - 1; j > 0; j--)
            history[j] = history[j - 1];
        history[0] = x;
        for (int p = 0; p < n_phase; p++)
        begin
            if (decim_cnt == 0)
            begin
                acc = '0;
                for (int j = 0; j < len; j++)
                    acc = acc + history[j] * coeffs[j * n_phase + p];
                // arithmetic shift rounds toward minus infinity
                scaled = acc >>> FRAC_BITS;
                r.last = 1'b0;
                r.sat  = 1'b1;
                if (scaled > OUT_MAX)
                    r.value = 16'sh7FFF;
                else if (scaled < OUT_MIN)
                    r.value = 16'sh8000;
                else
                begin
                    r.value = scaled[SAMPLE_W-1:0];
                    r.sat   = 1'b0;
                end
                expected_q.push_back(r);
            end
            if (int'(decim_cnt) + 1 >= n_div)
                decim_cnt = '0;
            else
                decim_cnt = decim_cnt + 4'd1;
        end
        if (expected_q.size() > first)
        begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got %0d last %0b sat %0b",
                     $time, out_sample, last, saturated);
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("out_sample", want.value, out_sample);
            compare_field("last", want.last, last);
            compare_field("saturated", want.sat, saturated);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_q  = INTERP_RESET;
            decim_q   = DECIM_RESET;
            taps_q    = TAPS_RESET;
            decim_cnt = '0;
            for (int i = 0; i < MAX_TAPS; i++)
                history[i] = '0;
            expected_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // retire the output first: its item was accepted on an earlier edge
            if (out_valid && out_ready)
                check_result();
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INTERP: interp_q = cfg_wdata[FACTOR_W-1:0];
                    CFG_DECIM:  decim_q  = cfg_wdata[FACTOR_W-1:0];
                    CFG_TAPS:   taps_q   = cfg_wdata[TAPS_W-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (op == OP_LOAD_COEFF)
                begin
                    if (coeff_index < MAX_TAPS)
                        coeffs[coeff_index] = coeff_value;
                end
                else
                    push_sample(sample);
            end
            outstanding = expected_q.size();
        end
    end

endmodule

/* dv/polyphase_rational_resampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler testbench
// Drives coefficient loads and samples through bursty valid/ready traffic
// over a series of interpolation, decimation and tap settings, with a
// stalling receiver; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler_tb;
    import prr_pkg::*;

    localparam int MAX_TAPS      = 256;
    localparam int MAX_FACTOR    = 16;
    localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 8 * MAX_FACTOR + 64;
    localparam int HOLD_CYCLES   = 3000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 50;

    // index past the register list; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE,
        RX_BEAT
    } rx_mode_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata   = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic                       op          = OP_SAMPLE;
    logic [CIDX_W-1:0]          coeff_index = '0;
    logic signed [COEFF_W-1:0]  coeff_value = '0;
    logic signed [SAMPLE_W-1:0] sample      = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
    logic                       saturated;

    int mismatches;
    int outstanding;
    int cycle_count;
    int stall_ticket = 0;
    int burst_left   = 0;
    bit coeff_loaded [MAX_TAPS];

    polyphase_rational_resampler #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .last        (last),
        .saturated   (saturated)
    );

    prr_checker #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .last        (last),
        .saturated   (saturated),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: segments of different ready patterns, plus long hold-offs on request.
    initial
    begin : receiver
        rx_mode_t mode;
        int       seg_left;
        int       served;
        mode     = RX_STREAM;
        seg_left = 0;
        served   = 0;
        forever
        begin
            @(posedge clk);
            if (stall_ticket != served)
            begin
                served = stall_ticket;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(8, 120);
            end
            seg_left--;
            case (mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                default:   out_ready <= (seg_left % 4 != 0);
            endcase
        end
    end

    // Mostly uniform words, with the corner values a quarter of the time.
    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Factor write data: bits above the register width are random and dropped.
    function automatic logic [CFG_DATA_W-1:0] draw_factor();
        logic [FACTOR_W-1:0] f;
        case ($urandom_range(0, 9))
            0:       f = '0;
            1:       f = 5'd16;
            2:       f = 5'($urandom_range(17, 31));
            3:       f = 5'd1;
            default: f = 5'($urandom_range(1, 8));
        endcase
        return {4'($urandom), f};
    endfunction

    // Keep tap counts short so the coefficient fill stays small.
    function automatic logic [CFG_DATA_W-1:0] draw_taps();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 9'($urandom_range(24, 32));
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [CIDX_W-1:0] idx,
                             input logic signed [COEFF_W-1:0] cval,
                             input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        op          <= kind;
        coeff_index <= idx;
        coeff_value <= cval;
        sample      <= smp;
        do @(posedge clk); while (!in_ready);
        if (kind == OP_LOAD_COEFF)
            coeff_loaded[idx] = 1'b1;
    endtask

    // Hold the sender until every result is in, then let the block finish its pass.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Apply a new setting while idle and load every coefficient it can read.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] l, input logic [CFG_DATA_W-1:0] m,
                               input logic [CFG_DATA_W-1:0] t);
        int te;
        drain_results();
        write_reg(CFG_INTERP, l);
        write_reg(CFG_DECIM, m);
        write_reg(CFG_TAPS, t);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, 9'($urandom));
        cfg_wr_en <= 1'b0;
        te = (t == 0) ? 1 : ((t > MAX_TAPS) ? MAX_TAPS : int'(t));
        for (int i = 0; i < te; i++)
            if (!coeff_loaded[i])
                send_item(OP_LOAD_COEFF, CIDX_W'(i), draw_word(), draw_word());
    endtask

    initial
    begin : stimulus
        int random_items;
        int n;
        random_items = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // full-scale coefficients so the sums clip both ways
        send_item(OP_LOAD_COEFF, 8'd0, 16'sh8000, draw_word());
        send_item(OP_LOAD_COEFF, 8'd1, 16'sh7FFF, draw_word());
        send_item(OP_LOAD_COEFF, 8'd2, 16'sh8000, draw_word());
        send_item(OP_LOAD_COEFF, 8'd3, 16'sh7FFF, draw_word());
        send_item(OP_LOAD_COEFF, 8'd255, 16'sh0001, draw_word());
        reconfigure(9'd2, 9'd1, 9'd4);
        send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), 16'sh8000);
        send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), 16'sh8000);
        send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), 16'sh7FFF);
        send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), 16'sh0000);
        send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), 16'shFFFF);

        // oversized factor, zero taps: more phases than taps, all-zero sums
        reconfigure(9'd31, 9'd3, 9'd0);
        repeat (3) send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), draw_word());

        // zero interpolation, oversized decimation: most samples give nothing
        reconfigure(9'd0, 9'd31, 9'd2);
        repeat (3) send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), draw_word());

        // lower the decimation below the running phase
        reconfigure(9'd3, 9'd2, 9'd7);
        repeat (3) send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), draw_word());

        // receiver holds off while samples keep coming, so the input backs up
        reconfigure(9'd4, 9'd1, 9'd12);
        stall_ticket <= stall_ticket + 1;
        repeat (12) send_item(OP_SAMPLE, CIDX_W'($urandom), draw_word(), draw_word());

        while (random_items < RANDOM_ITEMS)
        begin
            reconfigure(draw_factor(), draw_factor(), draw_taps());
            n = $urandom_range(4, 16);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_LOAD_COEFF, 8'($urandom), draw_word(), draw_word());
                else
                    send_item(OP_SAMPLE, 8'($urandom), draw_word(), draw_word());
                random_items++;
            end
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/prr_pkg.sv
hw/rtl/prr_ram.sv
hw/rtl/prr_ctrl.sv
hw/rtl/prr_dp.sv
hw/rtl/polyphase_rational_resampler.sv
dv/prr_checker.sv
dv/polyphase_rational_resampler_tb.sv
